>>> hw/rtl/bss_pkg.sv
// shared widths, command and status codes for the bounded stack with statistics
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package bss_pkg;

  localparam int CMD_W = 3;
  localparam int DATA_W = 32;
  localparam int STAT_W = 2;
  localparam int FILL_W = 5;
  localparam int CAP_W = 5;
  localparam int MAX_DEPTH_DEF = 16;

  localparam logic [CAP_W-1:0] CAP_RESET = 5'd10;

  localparam logic [CMD_W-1:0] CMD_PUSH = 3'd0;
  localparam logic [CMD_W-1:0] CMD_POP = 3'd1;
  localparam logic [CMD_W-1:0] CMD_PEEK = 3'd2;
  localparam logic [CMD_W-1:0] CMD_CLEAR = 3'd3;
  localparam logic [CMD_W-1:0] CMD_MAX = 3'd4;
  localparam logic [CMD_W-1:0] CMD_MIN = 3'd5;
  localparam logic [CMD_W-1:0] CMD_MEAN = 3'd6;

  localparam logic [STAT_W-1:0] ST_OK = 2'd0;
  localparam logic [STAT_W-1:0] ST_FULL = 2'd1;
  localparam logic [STAT_W-1:0] ST_EMPTY = 2'd2;

endpackage

`default_nettype wire

>>> hw/rtl/bss_if.sv
// valid/ready channel interfaces: command input, result output, capacity write
// depends on bss_pkg
`timescale 1ns / 1ps
`default_nettype none

interface bss_in_if;
  logic                            valid;
  logic                            ready;
  logic [bss_pkg::CMD_W-1:0]       cmd;
  logic signed [bss_pkg::DATA_W-1:0] push_value;

  modport source (output valid, output cmd, output push_value, input ready);
  modport sink (input valid, input cmd, input push_value, output ready);
endinterface

interface bss_out_if;
  logic                            valid;
  logic                            ready;
  logic [bss_pkg::STAT_W-1:0]      status;
  logic signed [bss_pkg::DATA_W-1:0] result_value;
  logic [bss_pkg::FILL_W-1:0]      fill_count;

  modport source (output valid, output status, output result_value, output fill_count,
                  input ready);
  modport sink (input valid, input status, input result_value, input fill_count,
                output ready);
endinterface

interface bss_cfg_if;
  logic                       valid;
  logic                       ready;
  logic [bss_pkg::CAP_W-1:0]  capacity;

  modport source (output valid, output capacity, input ready);
  modport sink (input valid, input capacity, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/bounded_stack_with_stats_top.sv
// top level of the bounded stack with statistics: capacity register, core, divider
// depends on bss_pkg, bss_if, bss_div, bss_core
//
//   channel  dir  fields                              transfer when
//   in_ch    in   cmd, push_value                     valid && ready
//   out_ch   out  status, result_value, fill_count    valid && ready
//   cfg_ch   in   capacity                            valid (ready always high)
//
// push, clear, unknown commands, full and empty answers: result registered in the cycle after the command is taken
// pop and peek: the registered read of the entry memory, then the output register
// max and min: a walk over the n entries, one memory read per cycle, then the output register
// mean: the walk, then the divider at one quotient bit per divider cycle
// reset clears the fill count and the output valid flag; capacity returns to 10
// a stalled result blocks new commands only once the held result is not taken
`timescale 1ns / 1ps
`default_nettype none

module bounded_stack_with_stats_top #(
  parameter int MAX_DEPTH = bss_pkg::MAX_DEPTH_DEF
) (
  input  wire        clk,
  input  wire        rst_n,
  bss_in_if.sink     in_ch,
  bss_out_if.source  out_ch,
  bss_cfg_if.sink    cfg_ch
);

  localparam int DEPTH_W = $clog2(MAX_DEPTH + 1);
  localparam int SUM_W = bss_pkg::DATA_W + $clog2(MAX_DEPTH) + 1;

  logic [bss_pkg::CAP_W-1:0] cap_r;
  logic                      div_start;
  logic signed [SUM_W-1:0]   div_num;
  logic [DEPTH_W-1:0]        div_den;
  logic                      div_done;
  logic signed [bss_pkg::DATA_W-1:0] div_quo;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= bss_pkg::CAP_RESET;
    end else if (cfg_ch.valid) begin
      cap_r <= cfg_ch.capacity;
    end
  end

  bss_core #(
    .MAX_DEPTH (MAX_DEPTH),
    .DEPTH_W   (DEPTH_W),
    .SUM_W     (SUM_W)
  ) u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .capacity  (cap_r),
    .div_start (div_start),
    .div_num   (div_num),
    .div_den   (div_den),
    .div_done  (div_done),
    .div_quo   (div_quo)
  );

  bss_div #(
    .NUM_W (SUM_W),
    .DEN_W (DEPTH_W)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quo   (div_quo)
  );

endmodule

`default_nettype wire

>>> hw/rtl/bss_div.sv
// radix-2 restoring divider for the mean: signed sum over unsigned count
// one quotient bit per cycle; depends on bss_pkg
`timescale 1ns / 1ps
`default_nettype none

module bss_div #(
  parameter int NUM_W = 37,
  parameter int DEN_W = 5
) (
  input  wire                               clk,
  input  wire                               rst_n,
  input  wire                               start,
  input  wire signed [NUM_W-1:0]            num,
  input  wire        [DEN_W-1:0]            den,
  output logic                              done,
  output logic signed [bss_pkg::DATA_W-1:0] quo
);

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [DEN_W-1:0] rem_r, rem_nxt;
  logic [NUM_W-1:0] q_r, q_nxt;
  logic [DEN_W-1:0] den_r, den_nxt;
  logic             neg_r, neg_nxt;

  logic [DEN_W:0]   trial;
  logic             fits;
  logic [bss_pkg::DATA_W-1:0] mag;

  always_comb begin
    trial = {rem_r, q_r[NUM_W-1]};
    fits = (trial >= {1'b0, den_r});
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt = cnt_r;
    rem_nxt = rem_r;
    q_nxt = q_r;
    den_nxt = den_r;
    neg_nxt = neg_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt = CNT_W'(NUM_W);
      rem_nxt = '0;
      q_nxt = num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
      den_nxt = den;
      neg_nxt = num[NUM_W-1];
    end else if (busy_r) begin
      rem_nxt = fits ? DEN_W'(trial - {1'b0, den_r}) : trial[DEN_W-1:0];
      q_nxt = {q_r[NUM_W-2:0], fits};
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    q_r <= q_nxt;
    den_r <= den_nxt;
    neg_r <= neg_nxt;
  end

  assign mag = q_r[bss_pkg::DATA_W-1:0];
  assign quo = neg_r ? -$signed(mag) : $signed(mag);
  assign done = done_r;

endmodule

`default_nettype wire

>>> hw/rtl/bss_core.sv
// stack controller: entry memory, fill counter, walk over entries, result register
// depends on bss_pkg, bss_if; drives the mean divider
`timescale 1ns / 1ps
`default_nettype none

module bss_core #(
  parameter int MAX_DEPTH = bss_pkg::MAX_DEPTH_DEF,
  parameter int DEPTH_W = $clog2(MAX_DEPTH + 1),
  parameter int SUM_W = bss_pkg::DATA_W + $clog2(MAX_DEPTH) + 1
) (
  input  wire                               clk,
  input  wire                               rst_n,
  bss_in_if.sink                            in_ch,
  bss_out_if.source                         out_ch,
  input  wire [bss_pkg::CAP_W-1:0]          capacity,
  output logic                              div_start,
  output logic signed [SUM_W-1:0]           div_num,
  output logic [DEPTH_W-1:0]                div_den,
  input  wire                               div_done,
  input  wire signed [bss_pkg::DATA_W-1:0]  div_quo
);

  localparam int ADDR_W = $clog2(MAX_DEPTH);
  localparam int DW = bss_pkg::DATA_W;
  localparam int CMP_W = (DEPTH_W > bss_pkg::CAP_W) ? DEPTH_W : bss_pkg::CAP_W;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_READ = 2'd1;
  localparam logic [1:0] S_WALK = 2'd2;
  localparam logic [1:0] S_DIV = 2'd3;

  logic signed [DW-1:0] mem [MAX_DEPTH];
  logic signed [DW-1:0] rd_data_r;

  logic [1:0]                 state_r, state_nxt;
  logic [DEPTH_W-1:0]         depth_r, depth_nxt;
  logic [DEPTH_W-1:0]         idx_r, idx_nxt;
  logic                       first_r, first_nxt;
  logic [bss_pkg::CMD_W-1:0]  cmd_r, cmd_nxt;
  logic signed [DW-1:0]       best_r, best_nxt;
  logic signed [SUM_W-1:0]    sum_r, sum_nxt;

  logic                       out_valid_r, out_valid_nxt;
  logic [bss_pkg::STAT_W-1:0] out_status_r, out_status_nxt;
  logic signed [DW-1:0]       out_result_r, out_result_nxt;
  logic [DEPTH_W-1:0]         out_depth_r, out_depth_nxt;

  logic                       accept;
  logic                       full;
  logic                       empty;
  logic [DEPTH_W-1:0]         depth_m1;
  logic                       wr_en;
  logic [ADDR_W-1:0]          wr_addr;
  logic                       rd_en;
  logic [ADDR_W-1:0]          rd_addr;
  logic                       take;
  logic signed [DW-1:0]       best_fold;
  logic signed [SUM_W-1:0]    sum_fold;
  logic                       walk_last;
  logic [DEPTH_W+bss_pkg::FILL_W-1:0] fill_ext;

  assign in_ch.ready = (state_r == S_IDLE) && (!out_valid_r || out_ch.ready);
  assign accept = in_ch.valid && in_ch.ready;
  assign empty = (depth_r == '0);
  assign full = (CMP_W'(depth_r) >= CMP_W'(capacity)) ||
                (depth_r == DEPTH_W'(MAX_DEPTH));
  assign depth_m1 = depth_r - 1'b1;
  assign walk_last = (idx_r == depth_r);

  always_comb begin
    take = first_r ||
           ((cmd_r == bss_pkg::CMD_MAX) ? (rd_data_r > best_r) : (rd_data_r < best_r));
    best_fold = take ? rd_data_r : best_r;
    sum_fold = first_r ? SUM_W'(rd_data_r) : sum_r + SUM_W'(rd_data_r);
  end

  always_comb begin
    state_nxt = state_r;
    depth_nxt = depth_r;
    idx_nxt = idx_r;
    first_nxt = first_r;
    cmd_nxt = cmd_r;
    best_nxt = best_r;
    sum_nxt = sum_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_status_nxt = out_status_r;
    out_result_nxt = out_result_r;
    out_depth_nxt = out_depth_r;
    wr_en = 1'b0;
    wr_addr = depth_r[ADDR_W-1:0];
    rd_en = 1'b0;
    rd_addr = depth_m1[ADDR_W-1:0];
    div_start = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          cmd_nxt = in_ch.cmd;
          out_status_nxt = bss_pkg::ST_OK;
          out_result_nxt = '0;
          out_depth_nxt = depth_r;
          case (in_ch.cmd) inside
            bss_pkg::CMD_PUSH: begin
              out_valid_nxt = 1'b1;
              if (full) begin
                out_status_nxt = bss_pkg::ST_FULL;
              end else begin
                wr_en = 1'b1;
                depth_nxt = depth_r + 1'b1;
                out_depth_nxt = depth_r + 1'b1;
              end
            end
            bss_pkg::CMD_POP, bss_pkg::CMD_PEEK: begin
              if (empty) begin
                out_valid_nxt = 1'b1;
                out_status_nxt = bss_pkg::ST_EMPTY;
              end else begin
                rd_en = 1'b1;
                state_nxt = S_READ;
                if (in_ch.cmd == bss_pkg::CMD_POP) begin
                  depth_nxt = depth_m1;
                end
              end
            end
            bss_pkg::CMD_CLEAR: begin
              out_valid_nxt = 1'b1;
              depth_nxt = '0;
              out_depth_nxt = '0;
            end
            bss_pkg::CMD_MAX, bss_pkg::CMD_MIN, bss_pkg::CMD_MEAN: begin
              if (empty) begin
                out_valid_nxt = 1'b1;
                out_status_nxt = bss_pkg::ST_EMPTY;
              end else begin
                rd_en = 1'b1;
                rd_addr = '0;
                idx_nxt = DEPTH_W'(1);
                first_nxt = 1'b1;
                state_nxt = S_WALK;
              end
            end
            default: begin
              out_valid_nxt = 1'b1;
            end
          endcase
        end
      end
      S_READ: begin
        out_valid_nxt = 1'b1;
        out_result_nxt = rd_data_r;
        out_depth_nxt = depth_r;
        state_nxt = S_IDLE;
      end
      S_WALK: begin
        first_nxt = 1'b0;
        best_nxt = best_fold;
        sum_nxt = sum_fold;
        if (walk_last) begin
          if (cmd_r == bss_pkg::CMD_MEAN) begin
            div_start = 1'b1;
            state_nxt = S_DIV;
          end else begin
            out_valid_nxt = 1'b1;
            out_result_nxt = best_fold;
            out_depth_nxt = depth_r;
            state_nxt = S_IDLE;
          end
        end else begin
          rd_en = 1'b1;
          rd_addr = idx_r[ADDR_W-1:0];
          idx_nxt = idx_r + 1'b1;
        end
      end
      S_DIV: begin
        if (div_done) begin
          out_valid_nxt = 1'b1;
          out_result_nxt = div_quo;
          out_depth_nxt = depth_r;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign div_num = sum_fold;
  assign div_den = depth_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      depth_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      depth_r <= depth_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r <= idx_nxt;
    first_r <= first_nxt;
    cmd_r <= cmd_nxt;
    best_r <= best_nxt;
    sum_r <= sum_nxt;
    out_status_r <= out_status_nxt;
    out_result_r <= out_result_nxt;
    out_depth_r <= out_depth_nxt;
  end

  // entry memory, one write and one read port, registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= in_ch.push_value;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign fill_ext = {{bss_pkg::FILL_W{1'b0}}, out_depth_r};
  assign out_ch.valid = out_valid_r;
  assign out_ch.status = out_status_r;
  assign out_ch.result_value = out_result_r;
  assign out_ch.fill_count = fill_ext[bss_pkg::FILL_W-1:0];

endmodule

`default_nettype wire

>>> hw/rtl/bss_checker.sv
// port-level checks for the bounded stack with statistics, bound to the top level
// depends on bss_pkg, bounded_stack_with_stats_top
`timescale 1ns / 1ps
`default_nettype none

module bss_checker (
  input wire                              clk,
  input wire                              rst_n,
  input wire                              in_valid,
  input wire                              in_ready,
  input wire [bss_pkg::CMD_W-1:0]         in_cmd,
  input wire                              out_valid,
  input wire                              out_ready,
  input wire [bss_pkg::STAT_W-1:0]        out_status,
  input wire [bss_pkg::DATA_W-1:0]        out_result,
  input wire [bss_pkg::FILL_W-1:0]        out_fill
);

  a_reset_clears_out: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_result) && $stable(out_status))
    else $error("stalled result changed");

  a_clear_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_cmd == bss_pkg::CMD_CLEAR |=>
      out_valid && out_fill == '0 && out_status == bss_pkg::ST_OK)
    else $error("clear did not answer with an empty ok result");

  a_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != bss_pkg::ST_OK |-> out_result == '0)
    else $error("nonzero value with an error status");

  a_empty_fill: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == bss_pkg::ST_EMPTY |-> out_fill == '0)
    else $error("empty status with entries held");

endmodule

bind bounded_stack_with_stats_top bss_checker u_bss_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_ch.valid),
  .in_ready   (in_ch.ready),
  .in_cmd     (in_ch.cmd),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .out_status (out_ch.status),
  .out_result (out_ch.result_value),
  .out_fill   (out_ch.fill_count)
);

`default_nettype wire

>>> dv/testbench.sv
// self-checking testbench for the bounded stack with statistics
// holds its own stack model in a scoreboard class, drives the command and result channels with random idling
// depends on bss_pkg, bss_if and bounded_stack_with_stats_top
`timescale 1ns / 1ps

module testbench;

  localparam int STACK_DEPTH = bss_pkg::MAX_DEPTH_DEF;
  localparam logic [bss_pkg::CMD_W-1:0] CMD_UNUSED = 3'd7;
  localparam int LIMIT_CYCLES = 400000;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int ITEMS_PER_PHASE = 120;
  localparam int NUM_PHASES = 12;
  localparam int SETTLE_CYCLES = 8;
  localparam int DRAIN_CYCLES = 80;
  localparam int REPORT_LIMIT = 40;

  typedef struct packed {
    logic [bss_pkg::STAT_W-1:0]        status;
    logic signed [bss_pkg::DATA_W-1:0] value;
    logic [bss_pkg::FILL_W-1:0]        fill;
  } stack_answer_t;

  class stack_scoreboard;
    logic signed [bss_pkg::DATA_W-1:0] held[STACK_DEPTH];
    int unsigned              depth;
    int unsigned              capacity;
    stack_answer_t            answers_due[$];
    int                       mismatches;
    int                       checked;
    int                       full_seen;
    int                       empty_seen;
    int                       cmd_seen[8];

    function new();
      depth = 0;
      capacity = bss_pkg::CAP_RESET;
      mismatches = 0;
      checked = 0;
      full_seen = 0;
      empty_seen = 0;
      foreach (cmd_seen[i]) cmd_seen[i] = 0;
    endfunction

    function int unsigned limit();
      return (capacity > STACK_DEPTH) ? STACK_DEPTH : capacity;
    endfunction

    function int pending();
      return answers_due.size();
    endfunction

    // work out the answer of one accepted command and update the stack copy
    function void note_command(logic [bss_pkg::CMD_W-1:0] cmd,
                               logic signed [bss_pkg::DATA_W-1:0] value);
      stack_answer_t                     a;
      logic signed [bss_pkg::DATA_W-1:0] best;
      longint                            total;
      a.status = bss_pkg::ST_OK;
      a.value = '0;
      cmd_seen[cmd]++;
      case (cmd)
        bss_pkg::CMD_PUSH: begin
          if (depth >= limit()) begin
            a.status = bss_pkg::ST_FULL;
          end else begin
            held[depth] = value;
            depth++;
          end
        end
        bss_pkg::CMD_POP: begin
          if (depth == 0) begin
            a.status = bss_pkg::ST_EMPTY;
          end else begin
            depth--;
            a.value = held[depth];
          end
        end
        bss_pkg::CMD_PEEK: begin
          if (depth == 0) a.status = bss_pkg::ST_EMPTY;
          else a.value = held[depth - 1];
        end
        bss_pkg::CMD_CLEAR: begin
          depth = 0;
        end
        bss_pkg::CMD_MAX, bss_pkg::CMD_MIN: begin
          if (depth == 0) begin
            a.status = bss_pkg::ST_EMPTY;
          end else begin
            best = held[0];
            for (int i = 1; i < depth; i++) begin
              if (cmd == bss_pkg::CMD_MAX ? (held[i] > best) : (held[i] < best))
                best = held[i];
            end
            a.value = best;
          end
        end
        bss_pkg::CMD_MEAN: begin
          if (depth == 0) begin
            a.status = bss_pkg::ST_EMPTY;
          end else begin
            total = 0;
            for (int i = 0; i < depth; i++) total += held[i];
            a.value = bss_pkg::DATA_W'(total / longint'(depth));
          end
        end
        default: begin
        end
      endcase
      if (a.status == bss_pkg::ST_FULL) full_seen++;
      if (a.status == bss_pkg::ST_EMPTY) empty_seen++;
      a.fill = bss_pkg::FILL_W'(depth);
      answers_due.push_back(a);
    endfunction

    task report(string what);
      if (mismatches < REPORT_LIMIT) $display("mismatch at %0t ns: %s", $time, what);
      mismatches++;
    endtask

    task check_answer(logic [bss_pkg::STAT_W-1:0] status,
                      logic signed [bss_pkg::DATA_W-1:0] value,
                      logic [bss_pkg::FILL_W-1:0] fill);
      stack_answer_t a;
      checked++;
      if (answers_due.size() == 0) begin
        report($sformatf("result %0d with nothing expected (status %0d value %0d fill %0d)",
                         checked, status, value, fill));
        return;
      end
      a = answers_due.pop_front();
      if (status !== a.status)
        report($sformatf("result %0d status got %0d want %0d", checked, status, a.status));
      if (value !== a.value)
        report($sformatf("result %0d value got %0d want %0d", checked, value, a.value));
      if (fill !== a.fill)
        report($sformatf("result %0d fill got %0d want %0d", checked, fill, a.fill));
    endtask
  endclass

  logic clk = 1'b0;
  logic rst_n;

  bss_in_if  in_ch ();
  bss_out_if out_ch ();
  bss_cfg_if cfg_ch ();

  bounded_stack_with_stats_top dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  stack_scoreboard sb = new();
  int burst_left = 0;
  bit hold_off_req = 1'b0;
  bit hold_off_done = 1'b0;

  always #2 clk = ~clk;

  function automatic logic signed [bss_pkg::DATA_W-1:0] rand_value();
    case ($urandom_range(0, 5))
      0: begin
        case ($urandom_range(0, 4))
          0: return 32'sh7fff_ffff;
          1: return 32'sh8000_0000;
          2: return 32'sd0;
          3: return -32'sd1;
          default: return 32'sd1;
        endcase
      end
      1, 2: return bss_pkg::DATA_W'(int'($urandom_range(0, 200)) - 100);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [bss_pkg::CMD_W-1:0] pick_cmd(int push_pct);
    int r;
    if ($urandom_range(0, 99) < push_pct) return bss_pkg::CMD_PUSH;
    r = $urandom_range(0, 99);
    if (r < 30) return bss_pkg::CMD_POP;
    if (r < 42) return bss_pkg::CMD_PEEK;
    if (r < 46) return bss_pkg::CMD_CLEAR;
    if (r < 62) return bss_pkg::CMD_MAX;
    if (r < 78) return bss_pkg::CMD_MIN;
    if (r < 94) return bss_pkg::CMD_MEAN;
    return CMD_UNUSED;
  endfunction

  // called at a falling edge, returns at the falling edge after the transfer
  task automatic send_item(input logic [bss_pkg::CMD_W-1:0] cmd,
                           input logic signed [bss_pkg::DATA_W-1:0] value);
    in_ch.valid <= 1'b1;
    in_ch.cmd <= cmd;
    in_ch.push_value <= value;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    sb.note_command(cmd, value);
    @(negedge clk);
  endtask

  // sender in bursts with random gaps in between
  task automatic offer(input logic [bss_pkg::CMD_W-1:0] cmd,
                       input logic signed [bss_pkg::DATA_W-1:0] value);
    if (burst_left == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    send_item(cmd, value);
  endtask

  task automatic settle();
    in_ch.valid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_capacity(input logic [bss_pkg::CAP_W-1:0] value);
    cfg_ch.valid <= 1'b1;
    cfg_ch.capacity <= value;
    do @(posedge clk); while (cfg_ch.ready !== 1'b1);
    sb.capacity = value;
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready)
      sb.check_answer(out_ch.status, out_ch.result_value, out_ch.fill_count);
  end

  // receiver stalls on modes of its own, plus one long hold-off on request
  initial begin : receiver
    int mode;
    int stretch;
    int k;
    out_ch.ready = 1'b0;
    k = 0;
    forever begin
      mode = $urandom_range(0, 3);
      stretch = $urandom_range(20, 120);
      repeat (stretch) begin
        @(negedge clk);
        k++;
        if (hold_off_req && !hold_off_done) begin
          hold_off_done = 1'b1;
          out_ch.ready <= 1'b0;
          repeat (HOLD_OFF_CYCLES) @(negedge clk);
        end
        case (mode)
          0: out_ch.ready <= 1'b1;
          1: out_ch.ready <= ($urandom_range(0, 99) < 75);
          2: out_ch.ready <= ($urandom_range(0, 99) < 25);
          default: out_ch.ready <= (k % 3 == 0);
        endcase
      end
    end
  end

  initial begin : watchdog
    repeat (LIMIT_CYCLES) @(posedge clk);
    $display("timeout after %0d cycles, %0d results still due", LIMIT_CYCLES, sb.pending());
    $display("status: fail");
    $finish;
  end

  initial begin : stimulus
    logic [bss_pkg::CAP_W-1:0] phase_caps[NUM_PHASES];
    logic [bss_pkg::CMD_W-1:0] cmd;
    int                        push_pct;
    int                        total;
    phase_caps = '{5'd16, 5'd3, 5'd31, 5'd1, 5'd0, 5'd17, 5'd8, 5'd16, 5'd2, 5'd12, 5'd5,
                   5'd24};
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.cmd = bss_pkg::CMD_PUSH;
    in_ch.push_value = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.capacity = bss_pkg::CAP_RESET;
    repeat (2) @(negedge clk);
    rst_n <= 1'b1;

    // empty stack, unused command, extremes, truncation of a negative mean
    offer(bss_pkg::CMD_POP, 32'sd0);
    offer(bss_pkg::CMD_PEEK, 32'sd0);
    offer(bss_pkg::CMD_MAX, 32'sd0);
    offer(bss_pkg::CMD_MIN, 32'sd0);
    offer(bss_pkg::CMD_MEAN, 32'sd0);
    offer(CMD_UNUSED, -32'sd1);
    offer(bss_pkg::CMD_PUSH, 32'sh7fff_ffff);
    offer(bss_pkg::CMD_PUSH, 32'sh8000_0000);
    offer(bss_pkg::CMD_PUSH, -32'sd3);
    offer(bss_pkg::CMD_PUSH, -32'sd4);
    offer(bss_pkg::CMD_PEEK, 32'sd0);
    offer(bss_pkg::CMD_MAX, 32'sd0);
    offer(bss_pkg::CMD_MIN, 32'sd0);
    offer(bss_pkg::CMD_MEAN, 32'sd0);
    offer(bss_pkg::CMD_POP, 32'sd0);
    offer(bss_pkg::CMD_POP, 32'sd0);
    offer(bss_pkg::CMD_MEAN, 32'sd0);
    offer(CMD_UNUSED, 32'sd0);
    offer(bss_pkg::CMD_CLEAR, -32'sd1);
    offer(bss_pkg::CMD_POP, 32'sd0);
    offer(bss_pkg::CMD_PUSH, -32'sd1);
    offer(bss_pkg::CMD_PEEK, 32'sd0);

    // even phases fill the stack up to full, odd ones push less under a new capacity, at times below the fill
    for (int p = 0; p < NUM_PHASES; p++) begin
      settle();
      write_capacity(phase_caps[p]);
      if (p == 0) hold_off_req = 1'b1;
      push_pct = (p % 2 == 0) ? $urandom_range(55, 75) : $urandom_range(15, 35);
      repeat (ITEMS_PER_PHASE) begin
        cmd = pick_cmd(push_pct);
        offer(cmd, rand_value());
      end
      if (p % 2 == 0) begin
        while (sb.depth < sb.limit()) offer(bss_pkg::CMD_PUSH, rand_value());
        offer(bss_pkg::CMD_PUSH, rand_value());
      end
    end

    settle();
    repeat (DRAIN_CYCLES) @(negedge clk);

    total = 0;
    foreach (sb.cmd_seen[i]) total += sb.cmd_seen[i];
    $display("covered %0d commands (push %0d, pop %0d, peek %0d, clear %0d, max %0d,",
             total, sb.cmd_seen[bss_pkg::CMD_PUSH], sb.cmd_seen[bss_pkg::CMD_POP],
             sb.cmd_seen[bss_pkg::CMD_PEEK], sb.cmd_seen[bss_pkg::CMD_CLEAR],
             sb.cmd_seen[bss_pkg::CMD_MAX]);
    $display("  min %0d, mean %0d, unused %0d) over %0d capacity settings",
             sb.cmd_seen[bss_pkg::CMD_MIN], sb.cmd_seen[bss_pkg::CMD_MEAN],
             sb.cmd_seen[CMD_UNUSED], NUM_PHASES + 1);
    $display("%0d results checked, %0d full and %0d empty answers, %0d mismatches",
             sb.checked, sb.full_seen, sb.empty_seen, sb.mismatches);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
